>>> rtl/core/swh_pkg.sv
// Shared types, constants and register codes for the single-wire humidity sensor reader.
`default_nettype none

package swh_pkg;

	// Frame length and the default width of the tick counter.
	localparam int FRAME_BITS      = 40;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int BITS_W          = 6;

	// Stream and configuration port widths.
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESP_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW_TO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH_TO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH   = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [15:0] START_LOW_RST    = 16'd20000;
	localparam logic [7:0]  RELEASE_HIGH_RST = 8'd30;
	localparam logic [9:0]  RESP_TIMEOUT_RST = 10'd200;
	localparam logic [9:0]  BIT_LOW_TO_RST   = 10'd100;
	localparam logic [9:0]  BIT_HIGH_TO_RST  = 10'd200;
	localparam logic [9:0]  ONE_THRESH_RST   = 10'd50;

	// Result status codes.
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_RESP_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_BIT_TIMEOUT  = 2'd2;
	localparam logic [1:0] ST_CHECKSUM     = 2'd3;

	// Phases of a reading.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DRIVE_LOW,
		PH_DRIVE_HIGH,
		PH_RESP_LOW,
		PH_RESP_HIGH,
		PH_RESP_END,
		PH_BIT_RISE,
		PH_BIT_FALL
	} phase_t;

	// Configuration register set.
	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_high_ticks;
		logic [9:0]  response_timeout;
		logic [9:0]  bit_low_timeout;
		logic [9:0]  bit_high_timeout;
		logic [9:0]  one_threshold;
	} cfg_t;

	// One result beat; the last member sits in the lowest bits.
	typedef struct packed {
		logic [7:0]        temperature_fraction;
		logic signed [7:0] temperature;
		logic [7:0]        humidity_fraction;
		logic [7:0]        humidity;
		logic [1:0]        status;
		logic              done_res;
		logic              busy_res;
		logic              drive_value;
		logic              drive_enable;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

>>> rtl/core/swh_cfg_regs.sv
// Configuration register file of the single-wire humidity sensor reader.
`default_nettype none

module swh_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [swh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [swh_pkg::CFG_DAT_W-1:0] cfg_data,
	output swh_pkg::cfg_t                      cfg
);
	import swh_pkg::*;

	cfg_t cfg_q;

	// Registers load on a write; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks    <= START_LOW_RST;
			cfg_q.release_high_ticks <= RELEASE_HIGH_RST;
			cfg_q.response_timeout   <= RESP_TIMEOUT_RST;
			cfg_q.bit_low_timeout    <= BIT_LOW_TO_RST;
			cfg_q.bit_high_timeout   <= BIT_HIGH_TO_RST;
			cfg_q.one_threshold      <= ONE_THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_LOW:    cfg_q.start_low_ticks    <= cfg_data;
				CFG_RELEASE_HIGH: cfg_q.release_high_ticks <= cfg_data[7:0];
				CFG_RESP_TIMEOUT: cfg_q.response_timeout   <= cfg_data[9:0];
				CFG_BIT_LOW_TO:   cfg_q.bit_low_timeout    <= cfg_data[9:0];
				CFG_BIT_HIGH_TO:  cfg_q.bit_high_timeout   <= cfg_data[9:0];
				CFG_ONE_THRESH:   cfg_q.one_threshold      <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/swh_step.sv
// Per-tick next-state and result logic of the single-wire humidity sensor reader.
`default_nettype none

module swh_step #(
	parameter int COUNT_WIDTH = swh_pkg::COUNT_WIDTH_DEF
) (
	input  wire swh_pkg::cfg_t               cfg,
	input  wire swh_pkg::phase_t             phase,
	input  wire logic [COUNT_WIDTH-1:0]      tick,
	input  wire logic [swh_pkg::BITS_W-1:0]  bits,
	input  wire logic [swh_pkg::FRAME_BITS-1:0] frame,
	input  wire logic                        start_req,
	input  wire logic                        pin_level,
	output swh_pkg::phase_t                  phase_nxt,
	output logic [COUNT_WIDTH-1:0]           tick_nxt,
	output logic [swh_pkg::BITS_W-1:0]       bits_nxt,
	output logic [swh_pkg::FRAME_BITS-1:0]   frame_nxt,
	output swh_pkg::res_t                    res
);
	import swh_pkg::*;

	logic [COUNT_WIDTH-1:0] tick_inc;
	logic [BITS_W-1:0]      bits_inc;
	logic [FRAME_BITS-1:0]  frame_sh;
	logic [7:0]             sum8;
	logic                   bit_val;

	assign tick_inc = tick + COUNT_WIDTH'(1);
	assign bits_inc = bits + BITS_W'(1);
	assign bit_val  = (tick_inc > COUNT_WIDTH'(cfg.one_threshold));
	assign frame_sh = {frame[FRAME_BITS-2:0], bit_val};
	assign sum8     = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];

	// Phase sequencing, pulse timing and frame assembly.
	always_comb begin
		logic       awaited;
		logic [9:0] limit;
		logic [1:0] fail_code;
		logic       done;
		logic       show;
		logic [1:0] status;

		phase_nxt = phase;
		tick_nxt  = tick;
		bits_nxt  = bits;
		frame_nxt = frame;
		done      = 1'b0;
		show      = 1'b0;
		status    = ST_OK;
		awaited   = 1'b0;
		limit     = cfg.response_timeout;
		fail_code = ST_RESP_TIMEOUT;

		// Level awaited and timeout of the wait phases.
		unique case (phase)
			PH_RESP_HIGH: awaited = 1'b1;
			PH_BIT_RISE: begin
				awaited   = 1'b1;
				limit     = cfg.bit_low_timeout;
				fail_code = ST_BIT_TIMEOUT;
			end
			PH_BIT_FALL: begin
				limit     = cfg.bit_high_timeout;
				fail_code = ST_BIT_TIMEOUT;
			end
			default: begin
			end
		endcase

		unique case (phase)
			PH_IDLE: begin
				if (start_req) begin
					phase_nxt = PH_DRIVE_LOW;
					tick_nxt  = COUNT_WIDTH'(1);
					bits_nxt  = '0;
					frame_nxt = '0;
				end
			end
			PH_DRIVE_LOW: begin
				if (tick >= COUNT_WIDTH'(cfg.start_low_ticks)) begin
					phase_nxt = PH_DRIVE_HIGH;
					tick_nxt  = COUNT_WIDTH'(1);
				end else begin
					tick_nxt = tick_inc;
				end
			end
			PH_DRIVE_HIGH: begin
				if (tick >= COUNT_WIDTH'(cfg.release_high_ticks)) begin
					phase_nxt = PH_RESP_LOW;
					tick_nxt  = '0;
				end else begin
					tick_nxt = tick_inc;
				end
			end
			default: begin
				tick_nxt = tick_inc;
				if (pin_level == awaited) begin
					tick_nxt = '0;
					priority case (phase)
						PH_BIT_FALL: begin
							frame_nxt = frame_sh;
							bits_nxt  = bits_inc;
							if (bits_inc >= BITS_W'(FRAME_BITS)) begin
								done      = 1'b1;
								show      = 1'b1;
								status    = (sum8 == frame_sh[7:0]) ? ST_OK : ST_CHECKSUM;
								phase_nxt = PH_IDLE;
							end else begin
								phase_nxt = PH_BIT_RISE;
							end
						end
						PH_RESP_END:  phase_nxt = PH_BIT_RISE;
						PH_BIT_RISE:  phase_nxt = PH_BIT_FALL;
						PH_RESP_LOW:  phase_nxt = PH_RESP_HIGH;
						PH_RESP_HIGH: phase_nxt = PH_RESP_END;
						default:      phase_nxt = PH_IDLE;
					endcase
				end else if (tick_inc >= COUNT_WIDTH'(limit)) begin
					done      = 1'b1;
					status    = fail_code;
					phase_nxt = PH_IDLE;
					tick_nxt  = '0;
				end
			end
		endcase

		// Result fields describe the state after this tick.
		res.drive_enable         = (phase_nxt == PH_DRIVE_LOW) || (phase_nxt == PH_DRIVE_HIGH);
		res.drive_value          = (phase_nxt == PH_DRIVE_HIGH);
		res.busy_res             = (phase_nxt != PH_IDLE);
		res.done_res             = done;
		res.status               = status;
		res.humidity             = show ? frame_sh[39:32] : 8'd0;
		res.humidity_fraction    = show ? frame_sh[31:24] : 8'd0;
		res.temperature          = show ? $signed(frame_sh[23:16]) : 8'sd0;
		res.temperature_fraction = show ? frame_sh[15:8] : 8'd0;
	end

endmodule

`default_nettype wire

>>> rtl/core/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity sensor reader: stream stages and state registers.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_*       in         start_req, pin_level; one beat per line sample tick
//  m_*       out        drive_enable, drive_value, busy_res, done_res, status,
//                       humidity, humidity_fraction, temperature, temperature_fraction
//  cfg_*     in         register write: index, data
//
// One beat is taken every cycle unless the result side stalls; each beat passes the
// input stage and then the result register. The throughput is set by the single step
// of the phase logic between the input stage and the result register. Reset loads the
// register defaults and puts the phase to idle. While m_tready is low the result holds,
// one more beat enters the input stage, and then s_tready drops.
`default_nettype none

module single_wire_humidity_sensor_reader #(
	parameter int COUNT_WIDTH = swh_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// s_tdata: [0] start_req, [1] pin_level, [7:2] zero
	input  wire logic [swh_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata: [0] drive_enable, [1] drive_value, [2] busy_res, [3] done_res,
	// [5:4] status, [13:6] humidity, [21:14] humidity_fraction,
	// [29:22] temperature, [37:30] temperature_fraction, [39:38] zero
	output logic [swh_pkg::M_TDATA_W-1:0]      m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [swh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [swh_pkg::CFG_DAT_W-1:0] cfg_data
);
	import swh_pkg::*;

	cfg_t                   cfg;
	logic                   valid_s1;
	logic                   start_s1;
	logic                   pin_s1;
	logic                   fire;
	phase_t                 phase_q;
	phase_t                 phase_nxt;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [COUNT_WIDTH-1:0] tick_nxt;
	logic [BITS_W-1:0]      bits_q;
	logic [BITS_W-1:0]      bits_nxt;
	logic [FRAME_BITS-1:0]  frame_q;
	logic [FRAME_BITS-1:0]  frame_nxt;
	res_t                   res;
	res_t                   res_q;
	logic                   m_valid_q;

	swh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swh_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.cfg       (cfg),
		.phase     (phase_q),
		.tick      (tick_q),
		.bits      (bits_q),
		.frame     (frame_q),
		.start_req (start_s1),
		.pin_level (pin_s1),
		.phase_nxt (phase_nxt),
		.tick_nxt  (tick_nxt),
		.bits_nxt  (bits_nxt),
		.frame_nxt (frame_nxt),
		.res       (res)
	);

	// A sample is processed when the result register is free or being emptied.
	assign fire     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			pin_s1   <= s_tdata[1];
		end
	end

	// Reading state advances once per processed sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bits_q  <= '0;
			frame_q <= '0;
		end else if (fire) begin
			phase_q <= phase_nxt;
			tick_q  <= tick_nxt;
			bits_q  <= bits_nxt;
			frame_q <= frame_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_TDATA_W - RES_W)'(0), res_q};

`ifndef SYNTHESIS
	// A finished reading leaves the block idle and off the line.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.done_res) |-> (!res_q.busy_res && !res_q.drive_enable))
		else $error("done result still reports busy or driving");

	// A status other than ok comes only with done.
	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (res_q.status != ST_OK)) |-> res_q.done_res)
		else $error("error status without done");

	// Idle without a start request stays idle.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (phase_q == PH_IDLE) && !start_s1) |=> (phase_q == PH_IDLE))
		else $error("left idle without a start request");

	// The bit counter never passes the frame length.
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_W'(FRAME_BITS))
		else $error("bit counter beyond frame length");

	// The result register reflects the phase reached by the processed sample.
	a_busy_matches: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (res_q.busy_res == (phase_q != PH_IDLE)))
		else $error("busy flag disagrees with phase");
`endif

endmodule

`default_nettype wire

>>> test/single_wire_humidity_sensor_reader_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the single-wire humidity sensor reader.

module single_wire_humidity_sensor_reader_test;
	import swh_pkg::*;

	// Segments of one sensor answer: line float, response low, response high,
	// 40 bit low/high pairs, final low, trailing idle high.
	localparam int NUM_SEGS = 85;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	// s_tdata: [0] start_req, [1] pin_level, [7:2] zero
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	// m_tdata: [0] drive_enable, [1] drive_value, [2] busy_res, [3] done_res,
	// [5:4] status, [13:6] humidity, [21:14] humidity_fraction,
	// [29:22] temperature, [37:30] temperature_fraction, [39:38] zero
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	// Our own copy of the reader state and of its timing registers.
	phase_t      rd_phase   = PH_IDLE;
	logic [15:0] tick_cnt   = '0;
	logic [5:0]  bit_cnt    = '0;
	logic [39:0] frame_word = '0;
	cfg_t        line_timing = {START_LOW_RST, RELEASE_HIGH_RST, RESP_TIMEOUT_RST,
		BIT_LOW_TO_RST, BIT_HIGH_TO_RST, ONE_THRESH_RST};

	res_t pending_readouts[$];
	int   send_idle_pct  = 21;
	int   recv_idle_pct  = 59;
	int   sample_count   = 0;
	int   readout_count  = 0;
	int   mismatch_count = 0;

	single_wire_humidity_sensor_reader u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// The result side stalls at random.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#5_000_000;
		$display("** single_wire_humidity_sensor_reader: FAILED **");
		$finish;
	end

	// Advances the reader by one line tick and returns the beat it must produce.
	function automatic res_t advance_reader(input logic start, input logic pin);
		res_t        r;
		logic        done;
		logic        show;
		logic        want;
		logic [1:0]  st;
		logic [1:0]  fail_st;
		logic [9:0]  lim;
		logic [7:0]  csum;
		r       = '0;
		done    = 1'b0;
		show    = 1'b0;
		want    = 1'b0;
		st      = ST_OK;
		fail_st = ST_RESP_TIMEOUT;
		lim     = '0;
		case (rd_phase)
			PH_IDLE: begin
				if (start) begin
					rd_phase   = PH_DRIVE_LOW;
					tick_cnt   = 16'd1;
					bit_cnt    = '0;
					frame_word = '0;
				end
			end
			PH_DRIVE_LOW: begin
				if (tick_cnt >= line_timing.start_low_ticks) begin
					rd_phase = PH_DRIVE_HIGH;
					tick_cnt = 16'd1;
				end else begin
					tick_cnt = tick_cnt + 16'd1;
				end
			end
			PH_DRIVE_HIGH: begin
				if (tick_cnt >= line_timing.release_high_ticks) begin
					rd_phase = PH_RESP_LOW;
					tick_cnt = '0;
				end else begin
					tick_cnt = tick_cnt + 16'd1;
				end
			end
			default: begin
				// Every remaining phase waits for one line level under a tick limit.
				case (rd_phase)
					PH_RESP_LOW, PH_RESP_END: begin
						want = 1'b0;
						lim  = line_timing.response_timeout;
					end
					PH_RESP_HIGH: begin
						want = 1'b1;
						lim  = line_timing.response_timeout;
					end
					PH_BIT_RISE: begin
						want    = 1'b1;
						lim     = line_timing.bit_low_timeout;
						fail_st = ST_BIT_TIMEOUT;
					end
					default: begin
						want    = 1'b0;
						lim     = line_timing.bit_high_timeout;
						fail_st = ST_BIT_TIMEOUT;
					end
				endcase
				tick_cnt = tick_cnt + 16'd1;
				if (pin == want) begin
					if (rd_phase == PH_BIT_FALL) begin
						// The pulse length decides the bit; frame is shifted in MSB first.
						frame_word = {frame_word[38:0], tick_cnt > line_timing.one_threshold};
						bit_cnt    = bit_cnt + 6'd1;
						if (bit_cnt >= FRAME_BITS) begin
							csum = frame_word[39:32] + frame_word[31:24] +
								frame_word[23:16] + frame_word[15:8];
							done     = 1'b1;
							show     = 1'b1;
							st       = (csum == frame_word[7:0]) ? ST_OK : ST_CHECKSUM;
							rd_phase = PH_IDLE;
						end else begin
							rd_phase = PH_BIT_RISE;
						end
					end else if (rd_phase == PH_RESP_END) begin
						rd_phase = PH_BIT_RISE;
					end else if (rd_phase == PH_BIT_RISE) begin
						rd_phase = PH_BIT_FALL;
					end else begin
						rd_phase = phase_t'(rd_phase + 1);
					end
					tick_cnt = '0;
				end else if (tick_cnt >= lim) begin
					done     = 1'b1;
					st       = fail_st;
					rd_phase = PH_IDLE;
					tick_cnt = '0;
				end
			end
		endcase
		r.drive_enable = (rd_phase == PH_DRIVE_LOW) || (rd_phase == PH_DRIVE_HIGH);
		r.drive_value  = (rd_phase == PH_DRIVE_HIGH);
		r.busy_res     = (rd_phase != PH_IDLE);
		r.done_res     = done;
		r.status       = st;
		if (show) begin
			r.humidity             = frame_word[39:32];
			r.humidity_fraction    = frame_word[31:24];
			r.temperature          = frame_word[23:16];
			r.temperature_fraction = frame_word[15:8];
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (mismatch_count < 100)
			$display("%0t: readout %0d %s: got %0d, expected %0d",
				$time, readout_count, what, got, want);
		mismatch_count++;
	endtask

	// Each result beat is compared with the oldest pending readout.
	always @(posedge clk) begin : check_readout
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RES_W-1:0];
			if (pending_readouts.size() == 0) begin
				flag_mismatch("beat with nothing pending, busy_res", got.busy_res, 0);
			end else begin
				want = pending_readouts.pop_front();
				if (got.drive_enable !== want.drive_enable)
					flag_mismatch("drive_enable", got.drive_enable, want.drive_enable);
				if (got.drive_value !== want.drive_value)
					flag_mismatch("drive_value", got.drive_value, want.drive_value);
				if (got.busy_res !== want.busy_res)
					flag_mismatch("busy_res", got.busy_res, want.busy_res);
				if (got.done_res !== want.done_res)
					flag_mismatch("done_res", got.done_res, want.done_res);
				if (got.status !== want.status)
					flag_mismatch("status", got.status, want.status);
				if (got.humidity !== want.humidity)
					flag_mismatch("humidity", got.humidity, want.humidity);
				if (got.humidity_fraction !== want.humidity_fraction)
					flag_mismatch("humidity_fraction", got.humidity_fraction,
						want.humidity_fraction);
				if (got.temperature !== want.temperature)
					flag_mismatch("temperature", got.temperature, want.temperature);
				if (got.temperature_fraction !== want.temperature_fraction)
					flag_mismatch("temperature_fraction", got.temperature_fraction,
						want.temperature_fraction);
			end
			readout_count++;
		end
	end

	// Sends one line tick as a beat, with random idle cycles ahead of it.
	task automatic send_sample(input logic start, input logic pin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-2){1'b0}}, pin, start};
		do @(posedge clk); while (!s_tready);
		pending_readouts.push_back(advance_reader(start, pin));
		sample_count++;
	endtask

	task automatic wait_readouts();
		s_tvalid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
	endtask

	// Holds the line high until the reader is idle; waits for a low level time out.
	task automatic finish_reading();
		while (rd_phase != PH_IDLE) send_sample(1'b0, 1'b1);
	endtask

	// Writes all six timing registers; unused upper data bits carry noise.
	task automatic load_timing(input cfg_t t);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_LOW;
		cfg_data  <= t.start_low_ticks;
		@(posedge clk);
		cfg_index <= CFG_RELEASE_HIGH;
		cfg_data  <= {8'($urandom), t.release_high_ticks};
		@(posedge clk);
		cfg_index <= CFG_RESP_TIMEOUT;
		cfg_data  <= {6'($urandom), t.response_timeout};
		@(posedge clk);
		cfg_index <= CFG_BIT_LOW_TO;
		cfg_data  <= {6'($urandom), t.bit_low_timeout};
		@(posedge clk);
		cfg_index <= CFG_BIT_HIGH_TO;
		cfg_data  <= {6'($urandom), t.bit_high_timeout};
		@(posedge clk);
		cfg_index <= CFG_ONE_THRESH;
		cfg_data  <= {6'($urandom), t.one_threshold};
		@(posedge clk);
		cfg_we      <= 1'b0;
		line_timing = t;
	endtask

	// Registers change only with the reader idle and every readout delivered.
	task automatic retime(input cfg_t t);
		finish_reading();
		wait_readouts();
		load_timing(t);
	endtask

	// Plays one start request and the sensor's answer. A fault of 1 corrupts the
	// checksum byte, 2 stretches one level past its tick limit.
	task automatic run_reading(input int fault);
		int          lens[NUM_SEGS];
		logic        lvls[NUM_SEGS];
		logic [39:0] word;
		int          k;
		int          j;
		int          lim;
		int          n_drive;
		word[39:8] = $urandom;
		word[7:0]  = word[39:32] + word[31:24] + word[23:16] + word[15:8];
		if (fault == 1)
			word[7:0] = word[7:0] ^ 8'($urandom_range(1, 255));

		// Response levels stay inside the response limit.
		lim     = (line_timing.response_timeout == 0) ? 1 : line_timing.response_timeout;
		lens[0] = $urandom_range(0, lim - 1);
		lvls[0] = 1'b1;
		lens[1] = $urandom_range(1, lim);
		lvls[1] = 1'b0;
		lens[2] = $urandom_range(1, lim);
		lvls[2] = 1'b1;

		// Data bits: a short low, then a high pulse whose length encodes the bit.
		for (k = 0; k < FRAME_BITS; k++) begin
			lvls[3+2*k] = 1'b0;
			lens[3+2*k] = $urandom_range(1, (line_timing.bit_low_timeout == 0) ? 1 :
				line_timing.bit_low_timeout);
			lvls[4+2*k] = 1'b1;
			if (word[39-k]) begin
				lens[4+2*k] = line_timing.one_threshold + 1 + $urandom_range(1);
				if (lens[4+2*k] > line_timing.bit_high_timeout)
					lens[4+2*k] = int'(line_timing.bit_high_timeout);
			end else begin
				lens[4+2*k] = $urandom_range(1, (line_timing.one_threshold == 0) ? 1 :
					line_timing.one_threshold);
			end
		end
		lens[83] = $urandom_range(1, 2);
		lvls[83] = 1'b0;
		lens[84] = $urandom_range(1, 4);
		lvls[84] = 1'b1;

		if (fault == 2) begin
			k = $urandom_range(0, 82);
			if (k < 3)
				lim = int'(line_timing.response_timeout);
			else if (lvls[k])
				lim = int'(line_timing.bit_high_timeout);
			else
				lim = int'(line_timing.bit_low_timeout);
			lens[k] += lim + $urandom_range(1, 3);
		end

		// Start tick, then the ticks on which the reader drives the line itself.
		n_drive = ((line_timing.start_low_ticks == 0) ? 1 : line_timing.start_low_ticks) +
			((line_timing.release_high_ticks == 0) ? 1 : line_timing.release_high_ticks);
		send_sample(1'b1, 1'($urandom_range(1)));
		repeat (n_drive)
			send_sample($urandom_range(7) == 0, 1'($urandom_range(1)));

		// Stray start requests land while busy and on the done tick.
		for (k = 0; k < NUM_SEGS; k++)
			for (j = 0; j < lens[k]; j++)
				send_sample((k < NUM_SEGS - 1) && ($urandom_range(7) == 0), lvls[k]);
	endtask

	// Idle ticks under the reset timing: nothing starts without a request.
	task automatic test_idle_ticks();
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b0, 1'b0);
	endtask

	// All registers zero: each wait fails on its first tick unless the level is there.
	task automatic test_zero_limits();
		// Each entry is {pin_level, start_req}.
		logic [1:0] steps[17] = '{
			2'b11, 2'b00, 2'b10, 2'b11,
			2'b01, 2'b10, 2'b00, 2'b00, 2'b00,
			2'b11, 2'b10, 2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b10};
		int i;
		retime('0);
		for (i = 0; i < 17; i++)
			send_sample(steps[i][0], steps[i][1]);
	endtask

	// Readings under random small timings: well-formed answers, corrupted
	// checksums, stretched levels and bursts of line noise.
	task automatic test_random_readings(input int quota);
		cfg_t t;
		int   stop_at;
		int   pick;
		stop_at = sample_count + quota;
		while (sample_count < stop_at) begin
			t.start_low_ticks    = 16'($urandom_range(0, 6));
			t.release_high_ticks = 8'($urandom_range(0, 4));
			t.response_timeout   = 10'($urandom_range(0, 6));
			t.bit_low_timeout    = 10'($urandom_range(1, 3));
			t.one_threshold      = 10'($urandom_range(0, 3));
			t.bit_high_timeout   = 10'(t.one_threshold + $urandom_range(1, 3));
			retime(t);
			pick = $urandom_range(99);
			if (pick < 10)
				repeat ($urandom_range(5, 30))
					send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (pick < 70)
				run_reading(0);
			else if (pick < 85)
				run_reading(1);
			else
				run_reading(2);
		end
	endtask

	// Wide registers: a start pulse past eight bits, then the longest limits and
	// threshold with a clean all-zero frame that must finish without a timeout.
	task automatic test_extreme_timing();
		int k;
		retime({16'h0100, 8'h20, 10'd0, 10'd0, 10'd0, 10'd0});
		send_sample(1'b1, 1'b0);
		finish_reading();

		retime({16'd0, 8'd0, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF});
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b1);
		send_sample(1'b0, 1'b1);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b0, 1'b0);
		for (k = 0; k < FRAME_BITS; k++) begin
			repeat ($urandom_range(2)) send_sample(1'b0, 1'b0);
			send_sample(1'b0, 1'b1);
			repeat ($urandom_range(3)) send_sample(1'b0, 1'b1);
			send_sample(1'b0, 1'b0);
		end
		finish_reading();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_ticks();
		test_zero_limits();
		test_random_readings(100);

		send_idle_pct = 59;
		recv_idle_pct = 21;
		test_random_readings(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_readings(100);
		test_extreme_timing();

		wait_readouts();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** single_wire_humidity_sensor_reader: PASSED **");
		else
			$display("** single_wire_humidity_sensor_reader: FAILED **");
		$finish;
	end

endmodule
